/* src/chained_hash_set_macros.svh */
// assertion helpers for the chained hash set
`ifndef CHAINED_HASH_SET_MACROS_SVH
`define CHAINED_HASH_SET_MACROS_SVH
`ifndef SYNTHESIS
`define CHS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CHS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CHS_ASSERT_SAME(lbl, ante, cons, msg)
`define CHS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* src/chs_pkg.sv */
`timescale 1ns / 1ps
package chs_pkg;
    localparam int DEF_BUCKET_COUNT = 31;
    localparam int DEF_POOL_ENTRIES = 64;
    localparam int KEY_W = 32;

    typedef logic [1:0] t_op;
    typedef logic [1:0] t_status;

    localparam t_op OP_INSERT = 2'd0;
    localparam t_op OP_SEARCH = 2'd1;
    localparam t_op OP_DELETE = 2'd2;
    localparam t_op OP_RSVD   = 2'd3;

    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_MISS = 2'd1;
    localparam t_status ST_FULL = 2'd2;
endpackage

/* src/chs_ifs.sv */
`timescale 1ns / 1ps
interface chs_req_if import chs_pkg::*; ();
    logic               valid;
    logic               ready;
    t_op                operation;
    logic signed [31:0] key_value;
    modport source (output valid, operation, key_value, input ready);
    modport sink (input valid, operation, key_value, output ready);
endinterface

interface chs_rsp_if import chs_pkg::*; ();
    logic    valid;
    logic    ready;
    t_status status;
    modport source (output valid, status, input ready);
    modport sink (input valid, status, output ready);
endinterface

/* src/chained_hash_set.sv */
`timescale 1ns / 1ps
// chained hash set of signed 32-bit values over a fixed entry pool
// i_req (sink): operation 0 insert, 1 search, 2 delete, plus key_value;
//   a word is taken when valid and ready are both high
// o_rsp (source): one status word per request: 0 ok or found,
//   1 duplicate or not found, 2 pool full
// steps per request: the bucket remainder, one key byte at a time through
//   the reciprocal multiplier (estimate, then subtract and correct), a read
//   of the bucket head, a walk of one chain entry per cycle, an update of the
//   memories on an insert or a delete, then the result is posted
// one request is in flight at a time; ready is low while it runs
// after reset a clearing pass over max(BUCKET_COUNT, POOL_ENTRIES) addresses
//   empties all buckets and links every entry onto the free list; no request
//   is taken during it
// the result sits in an output register; a new request is taken while it
//   waits, and the next result holds back until the receiver takes the old
module chained_hash_set import chs_pkg::*; #(
    parameter int BUCKET_COUNT = DEF_BUCKET_COUNT,
    parameter int POOL_ENTRIES = DEF_POOL_ENTRIES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    chs_req_if.sink   i_req,
    chs_rsp_if.source o_rsp
);
`include "chained_hash_set_macros.svh"
    localparam int BW   = $clog2(BUCKET_COUNT);
    localparam int IW   = $clog2(POOL_ENTRIES);
    localparam int LW   = $clog2(POOL_ENTRIES + 1);
    localparam int MAXD = (BUCKET_COUNT > POOL_ENTRIES) ? BUCKET_COUNT : POOL_ENTRIES;
    localparam int CW   = $clog2(MAXD);
    localparam logic [LW-1:0] NULL_L = LW'(POOL_ENTRIES);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_MOD  = 4'd2;
    localparam logic [3:0] S_HRD  = 4'd3;
    localparam logic [3:0] S_HUSE = 4'd4;
    localparam logic [3:0] S_WALK = 4'd5;
    localparam logic [3:0] S_ACT  = 4'd6;
    localparam logic [3:0] S_INSW = 4'd7;
    localparam logic [3:0] S_DEL1 = 4'd8;
    localparam logic [3:0] S_DEL2 = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    logic [LW-1:0]    heads [BUCKET_COUNT];
    logic [KEY_W-1:0] vals  [POOL_ENTRIES];
    logic [LW-1:0]    lnks  [POOL_ENTRIES];

    logic [3:0]       r_state, n_state;
    logic [CW-1:0]    r_clr, n_clr;
    t_op              r_op, n_op;
    logic [KEY_W-1:0] r_key, n_key;
    logic [BW-1:0]    r_bkt, n_bkt;
    logic [LW-1:0]    r_headv, n_headv;
    logic [LW-1:0]    r_cur, n_cur;
    logic [LW-1:0]    r_prev, n_prev;
    logic [LW-1:0]    r_nxt, n_nxt;
    logic [IW-1:0]    r_steps, n_steps;
    logic             r_hit, n_hit;
    logic [LW-1:0]    r_free, n_free;
    t_status          r_st, n_st;
    logic             r_out_valid, n_out_valid;
    t_status          r_out_st, n_out_st;

    logic [LW-1:0]    r_head_q;
    logic [KEY_W-1:0] r_val_q;
    logic [LW-1:0]    r_lnk_q;
    logic [IW-1:0]    w_rd_addr;

    logic             w_h_we;
    logic [BW-1:0]    w_h_addr;
    logic [LW-1:0]    w_h_data;
    logic             w_v_we;
    logic             w_l_we;
    logic [IW-1:0]    w_e_addr;
    logic [LW-1:0]    w_l_data;

    logic             w_accept;
    logic             w_rem_done;
    logic [BW-1:0]    w_rem_bkt;

    assign w_accept = i_req.valid && i_req.ready;

    chs_rem #(.BUCKET_COUNT(BUCKET_COUNT)) u_rem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_accept),
        .i_key    (i_req.key_value),
        .o_done   (w_rem_done),
        .o_bucket (w_rem_bkt)
    );

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_op        = r_op;
        n_key       = r_key;
        n_bkt       = r_bkt;
        n_headv     = r_headv;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_nxt       = r_nxt;
        n_steps     = r_steps;
        n_hit       = r_hit;
        n_free      = r_free;
        n_st        = r_st;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_st    = r_out_st;
        w_rd_addr   = r_cur[IW-1:0];
        w_h_we      = 1'b0;
        w_h_addr    = r_bkt;
        w_h_data    = NULL_L;
        w_v_we      = 1'b0;
        w_l_we      = 1'b0;
        w_e_addr    = r_free[IW-1:0];
        w_l_data    = r_headv;
        case (r_state)
            S_CLR: begin
                if ({1'b0, r_clr} < (CW + 1)'(BUCKET_COUNT)) begin
                    w_h_we   = 1'b1;
                    w_h_addr = r_clr[BW-1:0];
                end
                if ({1'b0, r_clr} < (CW + 1)'(POOL_ENTRIES)) begin
                    w_l_we   = 1'b1;
                    w_e_addr = r_clr[IW-1:0];
                    w_l_data = LW'({1'b0, r_clr} + (CW + 1)'(1));
                end
                n_clr = r_clr + CW'(1);
                if (r_clr == CW'(MAXD - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_op    = i_req.operation;
                    n_key   = KEY_W'(i_req.key_value);
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (w_rem_done) begin
                    n_bkt   = w_rem_bkt;
                    n_state = S_HRD;
                end
            end
            S_HRD: begin
                n_state = S_HUSE;
            end
            S_HUSE: begin
                n_headv   = r_head_q;
                n_cur     = r_head_q;
                n_prev    = NULL_L;
                n_steps   = '0;
                n_hit     = 1'b0;
                w_rd_addr = r_head_q[IW-1:0];
                n_state   = (r_head_q >= NULL_L) ? S_ACT : S_WALK;
            end
            S_WALK: begin
                // read data of the current entry is ready this cycle
                if (r_val_q == r_key) begin
                    n_hit   = 1'b1;
                    n_nxt   = r_lnk_q;
                    n_state = S_ACT;
                end else if ((r_lnk_q >= NULL_L) ||
                             (r_steps == IW'(POOL_ENTRIES - 1))) begin
                    n_state = S_ACT;
                end else begin
                    n_prev    = r_cur;
                    n_cur     = r_lnk_q;
                    n_steps   = r_steps + IW'(1);
                    w_rd_addr = r_lnk_q[IW-1:0];
                end
            end
            S_ACT: begin
                w_rd_addr = r_free[IW-1:0];
                n_state   = S_DONE;
                case (r_op)
                    OP_INSERT: begin
                        if (r_hit) begin
                            n_st = ST_MISS;
                        end else if (r_free >= NULL_L) begin
                            n_st = ST_FULL;
                        end else begin
                            n_st    = ST_OK;
                            n_state = S_INSW;
                        end
                    end
                    OP_SEARCH: begin
                        n_st = r_hit ? ST_OK : ST_MISS;
                    end
                    OP_DELETE: begin
                        n_st = r_hit ? ST_OK : ST_MISS;
                        if (r_hit) begin
                            n_state = S_DEL1;
                        end
                    end
                    default: begin
                        n_st = ST_MISS;
                    end
                endcase
            end
            S_INSW: begin
                // r_lnk_q holds the link of the free entry being taken
                w_v_we   = 1'b1;
                w_l_we   = 1'b1;
                w_e_addr = r_free[IW-1:0];
                w_l_data = r_headv;
                w_h_we   = 1'b1;
                w_h_data = r_free;
                n_free   = r_lnk_q;
                n_state  = S_DONE;
            end
            S_DEL1: begin
                if (r_prev >= NULL_L) begin
                    w_h_we   = 1'b1;
                    w_h_data = r_nxt;
                end else begin
                    w_l_we   = 1'b1;
                    w_e_addr = r_prev[IW-1:0];
                    w_l_data = r_nxt;
                end
                n_state = S_DEL2;
            end
            S_DEL2: begin
                w_l_we   = 1'b1;
                w_e_addr = r_cur[IW-1:0];
                w_l_data = r_free;
                n_free   = r_cur;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_st    = r_st;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_h_we) begin
            heads[w_h_addr] <= w_h_data;
        end
        r_head_q <= heads[r_bkt];
    end

    always_ff @(posedge i_clk) begin
        if (w_v_we) begin
            vals[w_e_addr] <= r_key;
        end
        if (w_l_we) begin
            lnks[w_e_addr] <= w_l_data;
        end
        r_val_q <= vals[w_rd_addr];
        r_lnk_q <= lnks[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_free      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
        end
        r_op     <= n_op;
        r_key    <= n_key;
        r_bkt    <= n_bkt;
        r_headv  <= n_headv;
        r_cur    <= n_cur;
        r_prev   <= n_prev;
        r_nxt    <= n_nxt;
        r_steps  <= n_steps;
        r_hit    <= n_hit;
        r_st     <= n_st;
        r_out_st <= n_out_st;
    end

    assign i_req.ready  = (r_state == S_IDLE);
    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.status = r_out_st;

    `CHS_ASSERT_SAME(a_no_take_in_clear, (r_state == S_CLR), !i_req.ready, "request taken during clear")
    `CHS_ASSERT_NEXT(a_accept_starts_div, w_accept, (r_state == S_MOD), "accepted word did not start")
    `CHS_ASSERT_SAME(a_alloc_valid, (r_state == S_INSW), (r_free < NULL_L), "insert from empty pool")
    `CHS_ASSERT_SAME(a_unlink_hit, (r_state == S_DEL1), r_hit, "delete without a hit")
endmodule

/* src/chs_rem.sv */
`timescale 1ns / 1ps
module chs_rem import chs_pkg::*; #(
    parameter int BUCKET_COUNT = DEF_BUCKET_COUNT,
    localparam int BW = $clog2(BUCKET_COUNT),
    localparam int XW = BW + 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [KEY_W-1:0] i_key,
    output logic                    o_done,
    output logic [BW-1:0]           o_bucket
);
    localparam int CHUNKS = KEY_W / 8;
    localparam int CNT_W  = $clog2(CHUNKS);
    localparam int PW     = XW + 32;
    localparam logic [31:0]   RECIP = 32'((64'd1 << 32) / BUCKET_COUNT);
    localparam logic [XW-1:0] B_X   = XW'(BUCKET_COUNT);

    logic             r_busy, n_busy;
    logic             r_phase, n_phase;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [KEY_W-1:0] r_mag, n_mag;
    logic [BW-1:0]    r_rem, n_rem;
    logic [XW-1:0]    r_q, n_q;
    logic             r_neg, n_neg;
    logic             r_done, n_done;
    logic [BW-1:0]    r_bkt, n_bkt;
    logic [XW-1:0]    w_x;
    logic [PW-1:0]    w_prod;
    logic [XW-1:0]    w_qb;
    logic [XW-1:0]    w_t;
    logic [XW-1:0]    w_r;

    // one key byte at a time: first estimate the quotient by the reciprocal,
    // then subtract and correct once
    assign w_x    = {r_rem, r_mag[KEY_W-1:KEY_W-8]};
    assign w_prod = PW'(w_x) * PW'(RECIP);
    assign w_qb   = r_q * B_X;
    assign w_t    = w_x - w_qb;
    assign w_r    = (w_t >= B_X) ? (w_t - B_X) : w_t;

    always_comb begin
        n_busy  = r_busy;
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_mag   = r_mag;
        n_rem   = r_rem;
        n_q     = r_q;
        n_neg   = r_neg;
        n_done  = 1'b0;
        n_bkt   = r_bkt;
        if (i_start) begin
            n_busy  = 1'b1;
            n_phase = 1'b0;
            n_cnt   = '0;
            n_neg   = i_key[KEY_W-1];
            n_mag   = i_key[KEY_W-1] ? (KEY_W'(0) - KEY_W'(i_key)) : KEY_W'(i_key);
            n_rem   = '0;
        end else if (r_busy) begin
            if (!r_phase) begin
                n_q     = w_prod[PW-1:32];
                n_phase = 1'b1;
            end else begin
                n_phase = 1'b0;
                n_rem   = w_r[BW-1:0];
                n_mag   = {r_mag[KEY_W-9:0], 8'h00};
                n_cnt   = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(CHUNKS - 1)) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                    // negative remainder folds up to the non-negative one
                    if (r_neg && (w_r != '0)) begin
                        n_bkt = BW'(B_X - w_r);
                    end else begin
                        n_bkt = w_r[BW-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_phase <= n_phase;
        r_mag   <= n_mag;
        r_rem   <= n_rem;
        r_q     <= n_q;
        r_neg   <= n_neg;
        r_bkt   <= n_bkt;
    end

    assign o_done   = r_done;
    assign o_bucket = r_bkt;
endmodule
